[rtl/pscs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs_pkg
// Shared widths, codes and request types of the proximity swap compact set.
// ----------------------------------------------------------------------------
package pscs_pkg;

    // default table depth
    localparam int MAX_TRIANGLES_DEF = 4096;

    // fixed field widths
    localparam int ID_W       = 12;
    localparam int COORD_W    = 24;
    localparam int ACT_W      = 2;
    localparam int SLOT_OUT_W = 12;
    localparam int CNT_OUT_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // squared distances stay below 2^50
    localparam int SQ_W  = 50;
    localparam int MAG_W = 25;

    // result action codes
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_RAD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOP_RAD = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]           tri_id;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
    } t_in_req;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic                  copy_valid;
        logic [SLOT_OUT_W-1:0] write_slot;
        logic [ID_W-1:0]       source_tri;
        logic [CNT_OUT_W-1:0]  active_count;
    } t_out_req;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_req;

endpackage

[rtl/pscs_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs_stream_if
// Valid/ready channel carrying one request payload of a chosen type.
// ----------------------------------------------------------------------------
interface pscs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/proximity_swap_compact_set.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_swap_compact_set
// Dense active triangle set with distance hysteresis and swap-and-pop removal.
// ----------------------------------------------------------------------------
// Usage
//   i_in  : one request per triangle (id and center, 8 fraction bits)
//   o_out : one result per request (action, copy slot and source, count)
//   i_cfg : register writes (index, data), always ready; write only when idle
// After reset the block sweeps both index tables to the identity mapping,
// one entry per cycle, with i_in.ready low.
// All triangles start active and substitution starts disabled.
// Per request: a shared 25x25 squarer runs five passes (dx, dy, dz, add
// radius, add+slop radius), then a decide state with the table update, an
// extra state for a removal that moves the last slot, and a state that loads
// the output register. A disabled or out-of-range id goes straight to the
// load state. A new request is taken only once the previous one is loaded.
// The output register holds a result until o_out.ready; the next request
// is computed meanwhile and waits in the load state if the output is full.
// ----------------------------------------------------------------------------
module proximity_swap_compact_set #(
    parameter int MAX_TRIANGLES = pscs_pkg::MAX_TRIANGLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pscs_stream_if.sink   i_in,
    pscs_stream_if.source o_out,
    pscs_stream_if.sink   i_cfg
);
    localparam int SLOT_W = $clog2(MAX_TRIANGLES);
    localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TRIANGLES - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_TRIANGLES);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_CLRID  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // squarer passes
    localparam logic [2:0] STEP_DX    = 3'd0;
    localparam logic [2:0] STEP_DY    = 3'd1;
    localparam logic [2:0] STEP_DZ    = 3'd2;
    localparam logic [2:0] STEP_ADD   = 3'd3;
    localparam logic [2:0] STEP_REM   = 3'd4;
    localparam logic [2:0] STEP_DRAIN = 3'd5;

    // configuration registers
    logic                               r_enable;
    logic signed [pscs_pkg::COORD_W-1:0] r_vx, r_vy, r_vz;
    logic [pscs_pkg::COORD_W-1:0]       r_add, r_slop;

    // control state
    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [2:0]        r_step, n_step;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // payload state
    logic [pscs_pkg::ID_W-1:0]           r_id, n_id;
    logic signed [pscs_pkg::COORD_W-1:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [pscs_pkg::SQ_W-1:0]           r_prod, n_prod;
    logic [pscs_pkg::SQ_W-1:0]           r_dist, n_dist;
    logic [pscs_pkg::SQ_W-1:0]           r_add2, n_add2;
    logic [pscs_pkg::SQ_W-1:0]           r_rem2, n_rem2;
    pscs_pkg::t_out_req                  r_res, n_res;
    pscs_pkg::t_out_req                  r_out, n_out;

    // table ports
    logic              slot_we, id_we;
    logic [SLOT_W-1:0] slot_wa, id_wa;
    logic [SLOT_W:0]   slot_wd;
    logic [SLOT_W-1:0] id_wd;
    logic [SLOT_W:0]   slot_rdata;
    logic [SLOT_W-1:0] id_rdata;
    logic [SLOT_W-1:0] id_addr;
    logic [CNT_W-1:0]  cnt_dec;
    logic [SLOT_W-1:0] last_slot;
    logic [SLOT_W-1:0] entry_slot;
    logic              entry_valid;

    // handshakes and decisions
    logic in_acc, out_acc, id_ok, do_remove, do_insert;

    // shared squarer operand
    logic signed [pscs_pkg::MAG_W-1:0] diff;
    logic [pscs_pkg::MAG_W-1:0]        mag;

    assign i_in.ready    = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = r_out_valid && o_out.ready;
    assign id_ok   = 32'(i_in.payload.tri_id) < 32'(MAX_TRIANGLES);

    assign id_addr     = SLOT_W'(r_id);
    assign cnt_dec     = r_count - CNT_W'(1);
    assign last_slot   = cnt_dec[SLOT_W-1:0];
    assign entry_valid = slot_rdata[SLOT_W];
    assign entry_slot  = slot_rdata[SLOT_W-1:0];

    // slot_of_id table: valid bit over slot number
    pscs_ram #(
        .DEPTH (MAX_TRIANGLES),
        .WIDTH (SLOT_W + 1)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_wa),
        .i_wdata (slot_wd),
        .i_raddr (id_addr),
        .o_rdata (slot_rdata)
    );

    // id_at_slot table, read at the last active slot
    pscs_ram #(
        .DEPTH (MAX_TRIANGLES),
        .WIDTH (SLOT_W)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_wa),
        .i_wdata (id_wd),
        .i_raddr (last_slot),
        .o_rdata (id_rdata)
    );

    // squarer operand select: coordinate differences, then the two radii
    always_comb begin
        diff = '0;
        mag  = '0;
        case (r_step)
            STEP_DX: begin
                diff = {r_cx[pscs_pkg::COORD_W-1], r_cx} - {r_vx[pscs_pkg::COORD_W-1], r_vx};
                mag  = diff[pscs_pkg::MAG_W-1] ? -diff : diff;
            end
            STEP_DY: begin
                diff = {r_cy[pscs_pkg::COORD_W-1], r_cy} - {r_vy[pscs_pkg::COORD_W-1], r_vy};
                mag  = diff[pscs_pkg::MAG_W-1] ? -diff : diff;
            end
            STEP_DZ: begin
                diff = {r_cz[pscs_pkg::COORD_W-1], r_cz} - {r_vz[pscs_pkg::COORD_W-1], r_vz};
                mag  = diff[pscs_pkg::MAG_W-1] ? -diff : diff;
            end
            STEP_ADD: begin
                mag = {1'b0, r_add};
            end
            STEP_REM: begin
                mag = {1'b0, r_add} + {1'b0, r_slop};
            end
            default: begin
                mag = '0;
            end
        endcase
    end

    // sequencer and table update
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_step      = r_step;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_id        = r_id;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_prod      = r_prod;
        n_dist      = r_dist;
        n_add2      = r_add2;
        n_rem2      = r_rem2;
        n_res       = r_res;
        n_out       = r_out;
        slot_we     = 1'b0;
        slot_wa     = r_clr;
        slot_wd     = {1'b1, r_clr};
        id_we       = 1'b0;
        id_wa       = r_clr;
        id_wd       = r_clr;
        do_remove   = 1'b0;
        do_insert   = 1'b0;

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // identity sweep after reset
            S_CLEAR: begin
                slot_we = 1'b1;
                id_we   = 1'b1;
                n_clr   = r_clr + SLOT_W'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            // take a request
            S_IDLE: begin
                if (in_acc) begin
                    n_id   = i_in.payload.tri_id;
                    n_cx   = i_in.payload.center_x;
                    n_cy   = i_in.payload.center_y;
                    n_cz   = i_in.payload.center_z;
                    n_step = STEP_DX;
                    n_dist = '0;
                    n_res  = '0;
                    n_res.action       = pscs_pkg::ACT_NONE;
                    n_res.active_count = pscs_pkg::CNT_OUT_W'(r_count);
                    if (r_enable && id_ok) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            // one square per cycle, registered and consumed in the following cycle
            S_MUL: begin
                if (r_step != STEP_DRAIN) begin
                    n_prod = mag * mag;
                end
                case (r_step)
                    STEP_DY, STEP_DZ, STEP_ADD: n_dist = r_dist + r_prod;
                    STEP_REM:                   n_add2 = r_prod;
                    STEP_DRAIN:                 n_rem2 = r_prod;
                    default:                    n_dist = r_dist;
                endcase
                if (r_step == STEP_DRAIN) begin
                    n_state = S_DECIDE;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            // hysteresis decision and first table writes
            S_DECIDE: begin
                n_state = S_DONE;
                if (entry_valid) begin
                    if (r_dist > r_rem2 && r_count != '0) begin
                        do_remove          = 1'b1;
                        n_count            = cnt_dec;
                        n_res.action       = pscs_pkg::ACT_REMOVE;
                        n_res.active_count = pscs_pkg::CNT_OUT_W'(cnt_dec);
                        if (entry_slot != last_slot) begin
                            // move the last active triangle into the freed slot
                            n_res.copy_valid = 1'b1;
                            n_res.write_slot = pscs_pkg::SLOT_OUT_W'(entry_slot);
                            n_res.source_tri = pscs_pkg::ID_W'(id_rdata);
                            slot_we = 1'b1;
                            slot_wa = id_rdata;
                            slot_wd = {1'b1, entry_slot};
                            id_we   = 1'b1;
                            id_wa   = entry_slot;
                            id_wd   = id_rdata;
                            n_state = S_CLRID;
                        end else begin
                            slot_we = 1'b1;
                            slot_wa = id_addr;
                            slot_wd = '0;
                        end
                    end
                end else if (r_dist < r_add2 && r_count < FULL_CNT) begin
                    // append at the active count
                    do_insert          = 1'b1;
                    n_count            = r_count + CNT_W'(1);
                    n_res.action       = pscs_pkg::ACT_INSERT;
                    n_res.copy_valid   = 1'b1;
                    n_res.write_slot   = pscs_pkg::SLOT_OUT_W'(r_count);
                    n_res.source_tri   = r_id;
                    n_res.active_count = pscs_pkg::CNT_OUT_W'(r_count + CNT_W'(1));
                    slot_we = 1'b1;
                    slot_wa = id_addr;
                    slot_wd = {1'b1, r_count[SLOT_W-1:0]};
                    id_we   = 1'b1;
                    id_wa   = r_count[SLOT_W-1:0];
                    id_wd   = id_addr;
                end
            end
            // invalidate the removed id
            S_CLRID: begin
                slot_we = 1'b1;
                slot_wa = id_addr;
                slot_wd = '0;
                n_state = S_DONE;
            end
            // load the output register once it is free
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_step      <= STEP_DX;
            r_count     <= FULL_CNT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_step      <= n_step;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_prod <= n_prod;
        r_dist <= n_dist;
        r_add2 <= n_add2;
        r_rem2 <= n_rem2;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_vx     <= '0;
            r_vy     <= '0;
            r_vz     <= '0;
            r_add    <= '0;
            r_slop   <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.payload.reg_index)
                pscs_pkg::REG_ENABLE:   r_enable <= i_cfg.payload.data[0];
                pscs_pkg::REG_VIEWER_X: r_vx     <= i_cfg.payload.data;
                pscs_pkg::REG_VIEWER_Y: r_vy     <= i_cfg.payload.data;
                pscs_pkg::REG_VIEWER_Z: r_vz     <= i_cfg.payload.data;
                pscs_pkg::REG_ADD_RAD:  r_add    <= i_cfg.payload.data;
                pscs_pkg::REG_SLOP_RAD: r_slop   <= i_cfg.payload.data;
                default: begin
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("active count above table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_remove |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("removal did not shrink the active count");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insertion did not grow the active count");

    a_no_copy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.copy_valid) |->
        (o_out.payload.write_slot == '0 && o_out.payload.source_tri == '0))
        else $error("slot or source set on a result without a copy");
`endif
endmodule

[rtl/pscs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pscs_ram #(
    parameter int DEPTH = pscs_pkg::MAX_TRIANGLES_DEF,
    parameter int WIDTH = pscs_pkg::ID_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
